// File: hw/rtl/tpe_pkg.sv
package tpe_pkg;

    localparam int NUM_PARTICLES = 4096;
    localparam int TABLE_DEPTH   = 4096;
    localparam int INDEX_SCALE   = 100;

    localparam int PA_W = $clog2(NUM_PARTICLES);
    localparam int TA_W = $clog2(TABLE_DEPTH);
    localparam logic [13:0] SCALE = 14'(INDEX_SCALE);

    localparam logic [2:0] OP_WPOS = 3'd0;
    localparam logic [2:0] OP_WTAB = 3'd1;
    localparam logic [2:0] OP_PAIR = 3'd2;
    localparam logic [2:0] OP_RDF  = 3'd3;
    localparam logic [2:0] OP_CLRE = 3'd4;

    localparam logic [1:0] ST_NONE = 2'd0;
    localparam logic [1:0] ST_USED = 2'd1;
    localparam logic [1:0] ST_PAST = 2'd2;

    localparam logic CFG_CUTOFF = 1'b0;
    localparam logic CFG_FDI    = 1'b1;

    localparam logic signed [47:0] F48_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] F48_MIN = 48'sh8000_0000_0000;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_pos;

    typedef struct packed {
        logic signed [47:0] x;
        logic signed [47:0] y;
        logic signed [47:0] z;
    } t_frc;

    typedef struct packed {
        logic signed [31:0] pot;
        logic signed [31:0] frc;
    } t_tab;

    typedef struct packed {
        logic            en;
        logic [PA_W-1:0] addr;
        t_pos            data;
    } t_pwr;

    typedef struct packed {
        logic            en;
        logic [PA_W-1:0] addr;
        t_frc            data;
    } t_fwr;

    typedef struct packed {
        logic            en;
        logic [TA_W-1:0] addr;
        t_tab            data;
    } t_twr;

    function automatic logic [PA_W-1:0] p_addr(input logic [11:0] v);
        logic [15:0] w;
        w = 16'(v);
        return w[PA_W-1:0];
    endfunction

    function automatic logic [TA_W-1:0] t_addr(input logic [47:0] v);
        return v[TA_W-1:0];
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [48:0] v);
        if (v[48] != v[47]) begin
            return v[48] ? F48_MIN : F48_MAX;
        end
        return v[47:0];
    endfunction

    function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
        return s[63:0];
    endfunction

endpackage

// File: hw/rtl/tpe_in_if.sv
interface tpe_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         opcode;
    logic [11:0]        first_index;
    logic [11:0]        second_index;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] charge_product;
    logic signed [31:0] table_potential;
    logic signed [31:0] table_force;

    modport source (output valid, opcode, first_index, second_index, pos_x, pos_y, pos_z,
                    charge_product, table_potential, table_force, input ready);
    modport sink (input valid, opcode, first_index, second_index, pos_x, pos_y, pos_z,
                  charge_product, table_potential, table_force, output ready);
endinterface

// File: hw/rtl/tpe_out_if.sv
interface tpe_out_if;
    logic               valid;
    logic               ready;
    logic signed [47:0] force_x;
    logic signed [47:0] force_y;
    logic signed [47:0] force_z;
    logic signed [63:0] energy_all;
    logic signed [63:0] energy_protein;
    logic signed [63:0] energy_dna;
    logic signed [63:0] energy_cross;
    logic [1:0]         pair_status;

    modport source (output valid, force_x, force_y, force_z, energy_all, energy_protein,
                    energy_dna, energy_cross, pair_status, input ready);
    modport sink (input valid, force_x, force_y, force_z, energy_all, energy_protein,
                  energy_dna, energy_cross, pair_status, output ready);
endinterface

// File: hw/rtl/tpe_particle_mem.sv
module tpe_particle_mem (
    input  logic                   i_clk,
    input  tpe_pkg::t_pwr          i_pwr,
    input  tpe_pkg::t_fwr          i_fwr,
    input  logic [tpe_pkg::PA_W-1:0] i_ra,
    input  logic [tpe_pkg::PA_W-1:0] i_rb,
    output tpe_pkg::t_pos          o_pa,
    output tpe_pkg::t_pos          o_pb,
    output tpe_pkg::t_frc          o_fa,
    output tpe_pkg::t_frc          o_fb
);
    import tpe_pkg::*;

    t_pos r_pos [NUM_PARTICLES];
    t_frc r_frc [NUM_PARTICLES];

    always_ff @(posedge i_clk) begin
        if (i_pwr.en) begin
            r_pos[i_pwr.addr] <= i_pwr.data;
        end
        o_pa <= r_pos[i_ra];
        o_pb <= r_pos[i_rb];
    end

    always_ff @(posedge i_clk) begin
        if (i_fwr.en) begin
            r_frc[i_fwr.addr] <= i_fwr.data;
        end
        o_fa <= r_frc[i_ra];
        o_fb <= r_frc[i_rb];
    end
endmodule

// File: hw/rtl/tpe_table_mem.sv
module tpe_table_mem (
    input  logic                     i_clk,
    input  tpe_pkg::t_twr            i_twr,
    input  logic [tpe_pkg::TA_W-1:0] i_ra,
    output tpe_pkg::t_tab            o_rd
);
    import tpe_pkg::*;

    t_tab r_tab [TABLE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_twr.en) begin
            r_tab[i_twr.addr] <= i_twr.data;
        end
        o_rd <= r_tab[i_ra];
    end
endmodule

// File: hw/rtl/tpe_force_unit.sv
// (fr * d) >> 32 toward zero, saturated to 48 bits; two register stages.
module tpe_force_unit (
    input  logic               i_clk,
    input  logic signed [63:0] i_fr,
    input  logic signed [32:0] i_d,
    output logic signed [47:0] o_term
);
    import tpe_pkg::*;

    logic [62:0] uf;
    logic [32:0] ud;
    logic [63:0] r_hi;
    logic [32:0] r_lo;
    logic        r_neg;
    logic [64:0] lo_full;
    logic [63:0] mag;

    always_comb begin
        uf      = i_fr[63] ? 63'(-i_fr) : i_fr[62:0];
        ud      = i_d[32] ? 33'(-i_d) : i_d[32:0];
        lo_full = 65'(uf[31:0]) * 65'(ud);
        mag     = r_hi + 64'(r_lo);
    end

    always_ff @(posedge i_clk) begin
        r_hi  <= 64'(uf[62:32]) * 64'(ud);
        r_lo  <= lo_full[64:32];
        r_neg <= i_fr[63] ^ i_d[32];
        if (r_neg) begin
            o_term <= (mag >= 64'h8000_0000_0000) ? F48_MIN : -$signed(mag[47:0]);
        end else begin
            o_term <= (mag > 64'h7FFF_FFFF_FFFF) ? F48_MAX : $signed(mag[47:0]);
        end
    end
endmodule

// File: hw/rtl/tabulated_pair_electrostatics_core.sv
// Tabulated pair electrostatics. Positions and force sums live in a 4096-entry particle
// memory, potential and force-over-r in a 4096-entry table memory. One word is handled at a
// time. A pair goes from its accept to the next accept through distance, square, table
// index, table read, charge scaling, two force split multiply stages, the two force
// write-backs on the single write port, then the result; a pair with an index out of range,
// outside the cutoff or past the table goes straight to the result. Every other opcode goes
// straight to the result. The result word sits in an output register, so the next word is
// taken while it waits. After reset the force store is zeroed one entry a cycle, so no word
// is accepted until every entry is clear; configuration writes are taken throughout.
module tabulated_pair_electrostatics_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [47:0]         i_cfg_data,
    tpe_in_if.sink              i_in,
    tpe_out_if.source           o_out
);
    import tpe_pkg::*;

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_DIFF = 4'd2;
    localparam logic [3:0] S_SQ   = 4'd3;
    localparam logic [3:0] S_IDX  = 4'd4;
    localparam logic [3:0] S_CHK  = 4'd5;
    localparam logic [3:0] S_MUL  = 4'd6;
    localparam logic [3:0] S_FT   = 4'd7;
    localparam logic [3:0] S_TERM = 4'd8;
    localparam logic [3:0] S_WA   = 4'd9;
    localparam logic [3:0] S_WB   = 4'd10;
    localparam logic [3:0] S_DONE = 4'd11;

    logic [3:0]         r_state;
    logic [PA_W-1:0]    r_clr;
    logic [47:0]        r_cutoff;
    logic [12:0]        r_fdi;
    logic [2:0]         r_op;
    logic [11:0]        r_i1, r_i2;
    logic [PA_W-1:0]    r_a, r_b;
    logic               r_aok, r_pok;
    logic signed [31:0] r_q;
    logic signed [32:0] r_dx, r_dy, r_dz;
    logic [49:0]        r_r2;
    logic [47:0]        r_idx;
    logic               r_inside;
    logic signed [63:0] r_e, r_fr;
    logic signed [63:0] r_eall, r_eprot, r_edna, r_ecross;
    logic [1:0]         r_status;
    logic               r_ovalid;

    logic               acc;
    logic [PA_W-1:0]    ra, rb;
    t_pos               pa, pb;
    t_frc               fa, fb, term;
    t_tab               trd;
    t_pwr               pwr;
    t_fwr               fwr;
    t_twr               twr;
    logic [32:0]        mx, my, mz;
    logic [65:0]        sx, sy, sz;
    logic [63:0]        sprod;
    logic               prot, dna;

    assign acc        = i_in.valid && r_state == S_IDLE;
    assign i_in.ready = r_state == S_IDLE;
    assign ra = acc ? p_addr(i_in.first_index) : r_a;
    assign rb = acc ? p_addr(i_in.second_index) : r_b;

    tpe_particle_mem u_pmem (
        .i_clk(i_clk), .i_pwr(pwr), .i_fwr(fwr), .i_ra(ra), .i_rb(rb),
        .o_pa(pa), .o_pb(pb), .o_fa(fa), .o_fb(fb)
    );

    tpe_table_mem u_tmem (
        .i_clk(i_clk), .i_twr(twr), .i_ra(t_addr(r_idx)), .o_rd(trd)
    );

    tpe_force_unit u_fx (.i_clk(i_clk), .i_fr(r_fr), .i_d(r_dx), .o_term(term.x));
    tpe_force_unit u_fy (.i_clk(i_clk), .i_fr(r_fr), .i_d(r_dy), .o_term(term.y));
    tpe_force_unit u_fz (.i_clk(i_clk), .i_fr(r_fr), .i_d(r_dz), .o_term(term.z));

    always_comb begin
        pwr.en     = acc && i_in.opcode == OP_WPOS
                     && 17'(i_in.first_index) < 17'(NUM_PARTICLES);
        pwr.addr   = p_addr(i_in.first_index);
        pwr.data.x = i_in.pos_x;
        pwr.data.y = i_in.pos_y;
        pwr.data.z = i_in.pos_z;

        twr.en       = acc && i_in.opcode == OP_WTAB
                       && 17'(i_in.first_index) < 17'(TABLE_DEPTH);
        twr.addr     = t_addr(48'(i_in.first_index));
        twr.data.pot = i_in.table_potential;
        twr.data.frc = i_in.table_force;

        fwr.en   = 1'b0;
        fwr.addr = r_a;
        fwr.data = '0;
        if (r_state == S_CLR) begin
            fwr.en   = 1'b1;
            fwr.addr = r_clr;
        end else if (pwr.en) begin
            fwr.en   = 1'b1;
            fwr.addr = pwr.addr;
        end else if (r_state == S_WA) begin
            fwr.en     = 1'b1;
            fwr.data.x = sat48({fa.x[47], fa.x} + {term.x[47], term.x});
            fwr.data.y = sat48({fa.y[47], fa.y} + {term.y[47], term.y});
            fwr.data.z = sat48({fa.z[47], fa.z} + {term.z[47], term.z});
        end else if (r_state == S_WB) begin
            fwr.en     = 1'b1;
            fwr.addr   = r_b;
            fwr.data.x = sat48({fb.x[47], fb.x} - {term.x[47], term.x});
            fwr.data.y = sat48({fb.y[47], fb.y} - {term.y[47], term.y});
            fwr.data.z = sat48({fb.z[47], fb.z} - {term.z[47], term.z});
        end

        mx = r_dx[32] ? 33'(-r_dx) : r_dx[32:0];
        my = r_dy[32] ? 33'(-r_dy) : r_dy[32:0];
        mz = r_dz[32] ? 33'(-r_dz) : r_dz[32:0];
        sx = 66'(mx) * 66'(mx);
        sy = 66'(my) * 66'(my);
        sz = 66'(mz) * 66'(mz);
        sprod = 64'(r_r2) * 64'(SCALE);
        prot  = 13'(r_i1) < r_fdi && 13'(r_i2) < r_fdi;
        dna   = 13'(r_i1) >= r_fdi && 13'(r_i2) >= r_fdi;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cutoff <= '0;
            r_fdi    <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_CUTOFF) begin
                r_cutoff <= i_cfg_data;
            end else begin
                r_fdi <= i_cfg_data[12:0];
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_op  <= i_in.opcode;
            r_i1  <= i_in.first_index;
            r_i2  <= i_in.second_index;
            r_a   <= ra;
            r_b   <= rb;
            r_q   <= i_in.charge_product;
            r_aok <= 17'(i_in.first_index) < 17'(NUM_PARTICLES);
            r_pok <= 17'(i_in.first_index) < 17'(NUM_PARTICLES)
                     && 17'(i_in.second_index) < 17'(NUM_PARTICLES);
        end
        r_dx     <= 33'(pa.x) - 33'(pb.x);
        r_dy     <= 33'(pa.y) - 33'(pb.y);
        r_dz     <= 33'(pa.z) - 33'(pb.z);
        r_r2     <= 50'(sx[65:16]) + 50'(sy[65:16]) + 50'(sz[65:16]);
        if (r_state == S_IDX) begin
            r_idx    <= sprod[63:16];
            r_inside <= r_r2 < {2'b00, r_cutoff};
        end
        r_e  <= trd.pot * r_q;
        r_fr <= 64'(trd.frc) * 64'(r_q);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_status <= ST_NONE;
            r_eall   <= '0;
            r_eprot  <= '0;
            r_edna   <= '0;
            r_ecross <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_state == S_DONE && (!r_ovalid || o_out.ready)) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == PA_W'(NUM_PARTICLES - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    r_status <= ST_NONE;
                    if (acc) begin
                        if (i_in.opcode == OP_CLRE) begin
                            r_eall   <= '0;
                            r_eprot  <= '0;
                            r_edna   <= '0;
                            r_ecross <= '0;
                        end
                        r_state <= (i_in.opcode == OP_PAIR) ? S_DIFF : S_DONE;
                    end
                end
                S_DIFF: r_state <= r_pok ? S_SQ : S_DONE;
                S_SQ:   r_state <= S_IDX;
                S_IDX:  r_state <= S_CHK;
                S_CHK: begin
                    if (!r_inside) begin
                        r_state <= S_DONE;
                    end else if (r_idx >= 48'(TABLE_DEPTH)) begin
                        r_status <= ST_PAST;
                        r_state  <= S_DONE;
                    end else begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL:  r_state <= S_FT;
                S_FT:   r_state <= S_TERM;
                S_TERM: begin
                    r_eall <= sat_add64(r_eall, r_e);
                    if (prot) begin
                        r_eprot <= sat_add64(r_eprot, r_e);
                    end else if (dna) begin
                        r_edna <= sat_add64(r_edna, r_e);
                    end else begin
                        r_ecross <= sat_add64(r_ecross, r_e);
                    end
                    r_status <= ST_USED;
                    r_state  <= S_WA;
                end
                S_WA:   r_state <= S_WB;
                S_WB:   r_state <= S_DONE;
                S_DONE: begin
                    if (!r_ovalid || o_out.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // result word
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && (!r_ovalid || o_out.ready)) begin
            if (r_op == OP_RDF && r_aok) begin
                o_out.force_x <= fa.x;
                o_out.force_y <= fa.y;
                o_out.force_z <= fa.z;
            end else begin
                o_out.force_x <= '0;
                o_out.force_y <= '0;
                o_out.force_z <= '0;
            end
            o_out.energy_all     <= r_eall;
            o_out.energy_protein <= r_eprot;
            o_out.energy_dna     <= r_edna;
            o_out.energy_cross   <= r_ecross;
            o_out.pair_status    <= r_status;
        end
    end

    assign o_out.valid = r_ovalid;

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CLR |-> !i_in.ready)
        else $error("word accepted during force clear");

    a_status_only_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_status != ST_NONE) |-> r_op == OP_PAIR)
        else $error("pair status on non-pair word");

    a_wb_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WB |-> (fwr.en && fwr.addr == r_b))
        else $error("second force write-back on wrong entry");
endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import tpe_pkg::*;

    typedef struct {
        bit [2:0]  op;
        bit [11:0] i1;
        bit [11:0] i2;
        bit [31:0] x, y, z, q, pot, frc;
    } cmd_t;

    typedef struct {
        bit [47:0] fx, fy, fz;
        bit [63:0] e_all, e_pro, e_dna, e_crs;
        bit [1:0]  status;
    } reply_t;

    localparam longint P48 = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint N48 = -64'sh0000_8000_0000_0000;

    class pair_force_scoreboard;
        bit signed [31:0] px[NUM_PARTICLES], py[NUM_PARTICLES], pz[NUM_PARTICLES];
        longint           fxs[NUM_PARTICLES], fys[NUM_PARTICLES], fzs[NUM_PARTICLES];
        bit signed [31:0] pot_tab[TABLE_DEPTH], frc_tab[TABLE_DEPTH];
        bit               placed[NUM_PARTICLES];
        bit               tab_set[TABLE_DEPTH];
        longint           e_all, e_pro, e_dna, e_crs;
        bit [47:0]        cutoff;
        bit [12:0]        fdi;
        reply_t           pending[$];
        int               errors;

        function void set_cfg(bit idx, bit [47:0] d);
            if (idx == CFG_CUTOFF) cutoff = d;
            else fdi = d[12:0];
        endfunction

        function bit [63:0] sq16(longint d);
            bit [63:0] m;
            m = d < 0 ? -d : d;
            return (m * m) >> 16;
        endfunction

        // r2 in Q16 and the table index it selects
        function void locate(int a, int b, output longint dx, dy, dz,
                             output bit [63:0] r2, output bit [63:0] idx);
            dx = longint'(px[a]) - longint'(px[b]);
            dy = longint'(py[a]) - longint'(py[b]);
            dz = longint'(pz[a]) - longint'(pz[b]);
            r2 = sq16(dx) + sq16(dy) + sq16(dz);
            idx = (64'(INDEX_SCALE) * r2) >> 16;
        endfunction

        function longint force_term(longint f, longint d);
            bit         neg;
            bit [127:0] p;
            bit [63:0]  m;
            neg = (f < 0) != (d < 0);
            p = 128'(f < 0 ? -f : f) * 128'(d < 0 ? -d : d);
            m = p[95:32];
            if (neg) return m >= 64'h8000_0000_0000 ? N48 : -longint'(m);
            return m > 64'(P48) ? P48 : longint'(m);
        endfunction

        function longint acc48(longint a, longint b);
            longint s;
            s = a + b;
            return s > P48 ? P48 : (s < N48 ? N48 : s);
        endfunction

        function longint acc64(longint a, longint b);
            longint s;
            s = a + b;
            if (a[63] == b[63] && s[63] != a[63])
                return a[63] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
            return s;
        endfunction

        function bit [1:0] pair_word(int a, int b, bit signed [31:0] q);
            longint    dx, dy, dz, e, fr, tx, ty, tz;
            bit [63:0] r2, idx;
            locate(a, b, dx, dy, dz, r2, idx);
            if (r2 >= 64'(cutoff)) return ST_NONE;
            if (idx >= TABLE_DEPTH) return ST_PAST;
            e = longint'(pot_tab[idx]) * longint'(q);
            e_all = acc64(e_all, e);
            if (a < fdi && b < fdi) e_pro = acc64(e_pro, e);
            else if (a >= fdi && b >= fdi) e_dna = acc64(e_dna, e);
            else e_crs = acc64(e_crs, e);
            fr = longint'(frc_tab[idx]) * longint'(q);
            tx = force_term(fr, dx);
            ty = force_term(fr, dy);
            tz = force_term(fr, dz);
            fxs[a] = acc48(fxs[a], tx);
            fxs[b] = acc48(fxs[b], -tx);
            fys[a] = acc48(fys[a], ty);
            fys[b] = acc48(fys[b], -ty);
            fzs[a] = acc48(fzs[a], tz);
            fzs[b] = acc48(fzs[b], -tz);
            return ST_USED;
        endfunction

        function void note(cmd_t c);
            reply_t r;
            r = '{default: 0};
            case (c.op)
                OP_WPOS: begin
                    px[c.i1] = c.x; py[c.i1] = c.y; pz[c.i1] = c.z;
                    fxs[c.i1] = 0; fys[c.i1] = 0; fzs[c.i1] = 0;
                    placed[c.i1] = 1;
                end
                OP_WTAB: begin
                    pot_tab[c.i1] = c.pot; frc_tab[c.i1] = c.frc; tab_set[c.i1] = 1;
                end
                OP_PAIR: r.status = pair_word(c.i1, c.i2, c.q);
                OP_RDF: begin
                    r.fx = 48'(fxs[c.i1]); r.fy = 48'(fys[c.i1]); r.fz = 48'(fzs[c.i1]);
                end
                OP_CLRE: begin
                    e_all = 0; e_pro = 0; e_dna = 0; e_crs = 0;
                end
                default: ;
            endcase
            r.e_all = e_all; r.e_pro = e_pro; r.e_dna = e_dna; r.e_crs = e_crs;
            pending.push_back(r);
        endfunction

        function void cmp(string name, logic [63:0] e, logic [63:0] a);
            if (a !== e) begin
                $error("%s: expected %h, got %h", name, e, a);
                errors++;
            end
        endfunction

        function void check(reply_t a);
            reply_t e;
            if (pending.size() == 0) begin
                $error("result word with nothing expected");
                errors++;
                return;
            end
            e = pending.pop_front();
            cmp("force_x", e.fx, a.fx);
            cmp("force_y", e.fy, a.fy);
            cmp("force_z", e.fz, a.fz);
            cmp("energy_all", e.e_all, a.e_all);
            cmp("energy_protein", e.e_pro, a.e_pro);
            cmp("energy_dna", e.e_dna, a.e_dna);
            cmp("energy_cross", e.e_crs, a.e_crs);
            cmp("pair_status", e.status, a.status);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [47:0] i_cfg_data;
    bit          calm;
    pair_force_scoreboard sb;

    tpe_in_if  in_ch ();
    tpe_out_if out_ch ();

    tabulated_pair_electrostatics_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("status: fail");
        $finish;
    end

    // receiver side: random backpressure, checked at the rising edge
    initial begin
        out_ch.ready = 0;
        forever begin
            @(negedge i_clk);
            out_ch.ready <= calm || $urandom_range(99) >= 11;
        end
    end

    always @(posedge i_clk) begin
        reply_t a;
        if (i_rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            a.fx = out_ch.force_x; a.fy = out_ch.force_y; a.fz = out_ch.force_z;
            a.e_all = out_ch.energy_all; a.e_pro = out_ch.energy_protein;
            a.e_dna = out_ch.energy_dna; a.e_crs = out_ch.energy_cross;
            a.status = out_ch.pair_status;
            sb.check(a);
        end
    end

    function automatic cmd_t rand_cmd();
        cmd_t c;
        c.op = $urandom; c.i1 = $urandom; c.i2 = $urandom;
        c.x = $urandom; c.y = $urandom; c.z = $urandom;
        c.q = $urandom; c.pot = $urandom; c.frc = $urandom;
        return c;
    endfunction

    function automatic bit [31:0] rand_coord();
        if ($urandom_range(9) == 0) return $urandom;
        return int'($urandom_range(393216)) - 196608;
    endfunction

    function automatic bit [31:0] rand_value();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom;
            default: return int'($urandom_range(262144)) - 131072;
        endcase
    endfunction

    task automatic send(cmd_t c);
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < 11) begin
            in_ch.valid <= 0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1;
        in_ch.opcode <= c.op;
        in_ch.first_index <= c.i1;
        in_ch.second_index <= c.i2;
        in_ch.pos_x <= c.x;
        in_ch.pos_y <= c.y;
        in_ch.pos_z <= c.z;
        in_ch.charge_product <= c.q;
        in_ch.table_potential <= c.pot;
        in_ch.table_force <= c.frc;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        sb.note(c);
    endtask

    task automatic place(int i, bit [31:0] x, bit [31:0] y, bit [31:0] z);
        cmd_t c;
        c = rand_cmd();
        c.op = OP_WPOS; c.i1 = i; c.x = x; c.y = y; c.z = z;
        send(c);
    endtask

    task automatic put_table(int i, bit [31:0] p, bit [31:0] f);
        cmd_t c;
        c = rand_cmd();
        c.op = OP_WTAB; c.i1 = i; c.pot = p; c.frc = f;
        send(c);
    endtask

    task automatic simple(bit [2:0] op, int i);
        cmd_t c;
        c = rand_cmd();
        c.op = op; c.i1 = i;
        send(c);
    endtask

    // fills the table entry a pair would hit, if it is still unset, before sending it
    task automatic pair(int a, int b, bit [31:0] q);
        cmd_t      c;
        longint    dx, dy, dz;
        bit [63:0] r2, idx;
        sb.locate(a, b, dx, dy, dz, r2, idx);
        if (r2 < 64'(sb.cutoff) && idx < TABLE_DEPTH && !sb.tab_set[idx])
            put_table(idx, rand_value(), rand_value());
        c = rand_cmd();
        c.op = OP_PAIR; c.i1 = a; c.i2 = b; c.q = q;
        send(c);
    endtask

    task automatic cfg_write(bit idx, bit [47:0] d);
        @(negedge i_clk);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= d;
        @(negedge i_clk);
        i_cfg_we <= 0;
        sb.set_cfg(idx, d);
    endtask

    // drop valid first so the last word is not taken twice
    task automatic drain(int extra);
        @(negedge i_clk);
        in_ch.valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    function automatic int pick_slot();
        case ($urandom_range(9))
            0: return $urandom_range(4095);
            1: return 4095;
            default: return $urandom_range(31);
        endcase
    endfunction

    task automatic random_phase(int n);
        int a, b, k;
        for (k = 0; k < n; k++) begin
            case ($urandom_range(19))
                0, 1, 2: place(pick_slot(), rand_coord(), rand_coord(), rand_coord());
                3, 4: put_table($urandom_range(4095), rand_value(), rand_value());
                5, 6, 7, 8: simple(OP_RDF, pick_slot());
                9: simple(k % 2 ? OP_CLRE : 3'($urandom_range(5, 7)), $urandom);
                default: begin
                    a = pick_slot();
                    b = $urandom_range(3) == 0 ? a : pick_slot();
                    if (!sb.placed[a]) place(a, rand_coord(), rand_coord(), rand_coord());
                    if (!sb.placed[b]) place(b, rand_coord(), rand_coord(), rand_coord());
                    pair(a, b, rand_value());
                end
            endcase
        end
    endtask

    initial begin
        int i;
        sb = new();
        i_rst_n = 0;
        i_cfg_we = 0;
        i_cfg_idx = 0;
        i_cfg_data = 0;
        in_ch.valid = 0;
        in_ch.opcode = 0;
        in_ch.first_index = 0;
        in_ch.second_index = 0;
        in_ch.pos_x = 0;
        in_ch.pos_y = 0;
        in_ch.pos_z = 0;
        in_ch.charge_product = 0;
        in_ch.table_potential = 0;
        in_ch.table_force = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // directed words
        cfg_write(CFG_CUTOFF, 48'hFFFF_FFFF_FFFF);
        cfg_write(CFG_FDI, 13'd2);
        place(0, 0, 0, 0);
        place(1, 32'h0001_0000, 0, 0);
        place(2, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        place(4095, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        place(3, 0, 0, -32'sd393216);
        put_table(0, 32'h7FFF_FFFF, 32'h8000_0000);
        put_table(100, 32'h8000_0000, 32'h7FFF_FFFF);
        put_table(3600, 32'h8000_0000, 32'h8000_0000);
        put_table(4095, 1, 32'hFFFF_FFFF);
        pair(0, 0, 32'h8000_0000);
        pair(0, 1, 32'h7FFF_FFFF);
        pair(0, 3, 32'h8000_0000);   // force far past 48 bits
        pair(3, 0, 32'h8000_0000);
        pair(2, 4095, 1);            // squared distance beyond the cutoff
        for (i = 0; i < 3; i++) pair(0, 0, 32'h8000_0000);
        simple(OP_RDF, 0);
        simple(OP_RDF, 3);
        simple(OP_RDF, 1);
        simple(OP_RDF, 4095);
        simple(OP_CLRE, 0);
        simple(3'd5, 0);
        simple(3'd6, 4095);
        simple(3'd7, 1);

        for (i = 4; i < 32; i++) place(i, rand_coord(), rand_coord(), rand_coord());
        random_phase(150);
        drain(20);
        cfg_write(CFG_CUTOFF, 48'd2684355);   // just over the table's reach
        cfg_write(CFG_FDI, 13'd16);
        calm = 1;
        random_phase(170);
        calm = 0;
        drain(20);
        cfg_write(CFG_CUTOFF, 48'd0);
        cfg_write(CFG_FDI, 13'd4096);
        random_phase(100);
        drain(20);
        cfg_write(CFG_CUTOFF, {$urandom_range(64), 16'($urandom)});
        cfg_write(CFG_FDI, 13'($urandom_range(4096)));
        random_phase(180);
        drain(20);
        cfg_write(CFG_CUTOFF, 48'd655360);
        cfg_write(CFG_FDI, 13'd8);
        random_phase(180);

        @(negedge i_clk);
        in_ch.valid <= 0;
        drain(30);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
